// ===== hdl/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
// Used by cdq_ctrl, cdq_datapath and circular_deque; depends on nothing.
`default_nettype none

package cdq_pkg;

  localparam int CMD_W  = 3;
  localparam int WORD_W = 32;
  localparam int CAP_W  = 5;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 72;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_out;
  } cdq_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/cdq_ctrl.sv =====
// Sequencing controller for the circular deque.
// Depends on cdq_pkg; drives the command struct into cdq_datapath.
`default_nettype none

module cdq_ctrl import cdq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output cdq_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;

  assign s_tready     = (state == S_IDLE);
  assign m_tvalid     = out_valid;
  assign cmd.capture  = s_tready && s_tvalid;
  assign cmd.execute  = (state == S_EXEC);
  assign cmd.load_out = (state == S_DONE) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: state_next = S_READ;
      S_READ: state_next = S_DONE;
      S_DONE: begin
        if (cmd.load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A finished result waits in DONE while the output register is still occupied.
  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !m_tready) |=> (state == S_DONE))
    else $error("result left DONE while output register was occupied");

endmodule

`default_nettype wire

// ===== hdl/cdq_datapath.sv =====
// Datapath of the circular deque: capacity register, ring indices, ring store
// and result register. Depends on cdq_pkg; steered by cdq_ctrl.
`default_nettype none

module cdq_datapath import cdq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CAP_W-1:0]  cfg_wdata,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [WORD_W-1:0] in_value,
  input  wire cdq_cmd_t          cmd,
  output logic                   accepted,
  output logic [WORD_W-1:0]      front_value,
  output logic [WORD_W-1:0]      back_value,
  output logic                   is_empty,
  output logic                   is_full
);

  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = ((IW > CAP_W) ? IW : CAP_W) + 1;

  logic [CAP_W-1:0]      capacity;
  logic [CAP_W-1:0]      cap_use;
  logic [CMP_W-1:0]      cap_w;
  logic [IW-1:0]         head;
  logic [IW-1:0]         head_next;
  logic [IW-1:0]         tail;
  logic [IW-1:0]         tail_next;
  logic [CAP_W-1:0]      count;
  logic [CAP_W-1:0]      count_next;
  logic [CMD_W-1:0]      cmd_r;
  logic [WORD_W-1:0]     value_r;
  logic                  ok_r;
  logic                  ok_next;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [63:0]           value_ext;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_front;
  logic [DATA_WIDTH-1:0] rd_back;
  logic [63:0]           front_ext;
  logic [63:0]           back_ext;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx,
                                              input logic [CMP_W-1:0] cap);
    logic [CMP_W-1:0] inc;
    inc = CMP_W'(idx) + CMP_W'(1);
    return (inc >= cap) ? IW'(0) : IW'(inc);
  endfunction

  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx,
                                              input logic [CMP_W-1:0] cap);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(idx);
    if (wide == '0 || wide >= cap) begin
      return IW'(cap - CMP_W'(1));
    end
    return IW'(wide - CMP_W'(1));
  endfunction

  // A capacity of zero behaves as one; anything above the store depth is clamped.
  always_comb begin
    if (capacity == '0) begin
      cap_use = CAP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      cap_use = CAP_W'(DEPTH);
    end else begin
      cap_use = capacity;
    end
    cap_w = CMP_W'(cap_use);
  end

  assign value_ext = 64'(value_r);
  assign wr_data   = value_ext[DATA_WIDTH-1:0];
  assign front_ext = 64'(rd_front);
  assign back_ext  = 64'(rd_back);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ok_next    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head;
    unique case (cmd_r) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (count < cap_use) begin
          wr_en      = 1'b1;
          ok_next    = 1'b1;
          count_next = count + CAP_W'(1);
          if (count == '0) begin
            head_next = '0;
            tail_next = '0;
            wr_addr   = '0;
          end else if (cmd_r == CMD_PUSH_FRONT) begin
            head_next = ring_prev(head, cap_w);
            wr_addr   = head_next;
          end else begin
            tail_next = ring_next(tail, cap_w);
            wr_addr   = tail_next;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (count != '0) begin
          ok_next = 1'b1;
          if (count == CAP_W'(1)) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
          end else begin
            if (cmd_r == CMD_POP_FRONT) begin
              head_next = ring_next(head, cap_w);
            end else begin
              tail_next = ring_prev(tail, cap_w);
            end
            count_next = count - CAP_W'(1);
          end
        end
      end
      CMD_QUERY: ok_next = 1'b1;
      default: ok_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
    end else if (cmd.execute) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_command;
      value_r <= in_value;
    end
    if (cmd.execute) begin
      ok_r <= ok_next;
    end
    if (cmd.load_out) begin
      accepted    <= ok_r;
      front_value <= (count != '0) ? front_ext[WORD_W-1:0] : '0;
      back_value  <= (count != '0) ? back_ext[WORD_W-1:0] : '0;
      is_empty    <= (count == '0);
      is_full     <= (count == cap_use);
    end
  end

  // Ring store: one write port, two registered read ports at the end indices.
  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_front <= mem[head];
    rd_back  <= mem[tail];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cap_use)
    else $error("entry count exceeds capacity in use");

  a_empty_home: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == '0 && tail == '0))
    else $error("empty deque with indices away from zero");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (CMP_W'(head) < cap_w && CMP_W'(tail) < cap_w))
    else $error("ring index outside capacity in use");

endmodule

`default_nettype wire

// ===== hdl/circular_deque.sv =====
// Top level of the circular deque: stream ports, configuration port and the
// controller/datapath pair. Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
//
//   Channel  Direction  Signals                     Contents
//   s        in         s_tvalid s_tready s_tdata   one command item
//   m        out        m_tvalid m_tready m_tdata   one result per item
//   cfg      in         cfg_we cfg_wdata            capacity register
//
// An item's result is ready on m after its transfer on s, through index
// update and store write, registered store read, and load of the output
// register. A new item is taken once the previous one has reached the output
// register, so the block does not take a new item while one is in flight;
// the output load waits while m still holds an unaccepted result.
// Reset sets capacity to 16 and empties the deque; the store is not cleared.
// A stalled result waits in the output register while the next item is taken.
`default_nettype none

module circular_deque import cdq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,  // capacity
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,    // command[2:0], value[34:3]
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata     // accepted[0], front_value[32:1],
                                            // back_value[64:33], is_empty[65],
                                            // is_full[66]
);

  cdq_cmd_t          cmd;
  logic              accepted;
  logic [WORD_W-1:0] front_value;
  logic [WORD_W-1:0] back_value;
  logic              is_empty;
  logic              is_full;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_command  (s_tdata[CMD_W-1:0]),
    .in_value    (s_tdata[CMD_W+WORD_W-1:CMD_W]),
    .cmd         (cmd),
    .accepted    (accepted),
    .front_value (front_value),
    .back_value  (back_value),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

  assign m_tdata = {5'b0, is_full, is_empty, back_value, front_value, accepted};

endmodule

`default_nettype wire
